// ===== rtl/ed332_pkg.sv =====
`default_nettype none

package ed332_pkg;

    localparam int CNT_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int ADDR_W  = 17;
    localparam int CHAN_W  = 8;
    localparam int INDEX_W = 8;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam logic [SIZE_W-1:0] SIZE_MAX     = 13'd4096;
    localparam logic [SIZE_W-1:0] RESET_WIDTH  = 13'd320;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = 13'd208;

    typedef enum logic [0:0] {
        CFG_SOURCE_WIDTH  = 1'b0,
        CFG_SOURCE_HEIGHT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic                 frame_last;
        logic [ADDR_W-1:0]    fb_address;
        logic [INDEX_W-1:0]   color_index;
    } t_result;

    // 0 acts as 1, anything above 4096 acts as 4096
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        begin
            if (v == '0) begin
                r = SIZE_W'(1);
            end else if (v > SIZE_MAX) begin
                r = SIZE_MAX;
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

    function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] a,
                                                  input logic [5:0]        b);
        logic [CHAN_W:0] s;
        begin
            s = {1'b0, a} + {3'b000, b};
            return s[CHAN_W] ? {CHAN_W{1'b1}} : s[CHAN_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/error_diffusion_rgb332_quantizer_top.sv =====
// RGB888 to RGB332 error-diffusion quantizer.
// Slave stream (i_s_*): one source pixel per request in raster order over a
// frame of source_width x source_height. Only the top-left window of
// MAX_COLS x MAX_ROWS is kept; other pixels are consumed with no result.
// Master stream (o_m_*): one request per kept pixel carrying the palette
// index (B[7:6] G[7:5] R[7:5] after adding the carried error) and its
// frame-buffer address; tlast marks the last kept pixel of a frame.
// Config channel (i_cfg_*): index 0 writes source_width, 1 source_height;
// always ready, write only while the stream is idle.
// A result is registered on o_m_*, or in the skid register while one waits.
// Throughput: one pixel per cycle while o_s_tready is high; the carry
// add/clamp and counter update sit between pixel state and output register.
// Stall: a skid register holds one extra result, so a pixel is taken even
// while a result waits; o_s_tready drops only when both registers are full.
// Reset: counters and carries clear, sizes return to 320 x 208, output
// registers empty.
`default_nettype none

module error_diffusion_rgb332_quantizer_top #(
    parameter int MAX_COLS = 320,
    parameter int MAX_ROWS = 208
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    input  wire logic [ed332_pkg::IN_DATA_W-1:0]    i_s_tdata,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [7:0] color_index, [24:8] fb_address, [31:25] zero
    output logic [ed332_pkg::OUT_DATA_W-1:0]        o_m_tdata,
    output logic                                    o_m_tlast,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire ed332_pkg::t_cfg_index              i_cfg_index,
    input  wire logic [ed332_pkg::SIZE_W-1:0]       i_cfg_data
);

    import ed332_pkg::*;

    localparam logic [SIZE_W-1:0] COLS_LIM = SIZE_W'(MAX_COLS);
    localparam logic [SIZE_W-1:0] ROWS_LIM = SIZE_W'(MAX_ROWS);
    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(MAX_COLS);

    function automatic logic [SIZE_W-1:0] clip(input logic [SIZE_W-1:0] v,
                                               input logic [SIZE_W-1:0] lim);
        return (v < lim) ? v : lim;
    endfunction

    logic [SIZE_W-1:0] r_w, r_h, r_win_w, r_win_h;
    logic [SIZE_W-1:0] n_w, n_h, n_win_w, n_win_h;
    logic [CNT_W-1:0]  r_col, r_row, n_col, n_row;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [4:0]        r_car_r, r_car_g, n_car_r, n_car_g;
    logic [5:0]        r_car_b, n_car_b;
    t_result           r_out, r_skid, n_out, n_skid, res;
    logic              r_out_valid, r_skid_valid, n_out_valid, n_skid_valid;

    logic              take, keep, spread, out_fire;
    logic [SIZE_W-1:0] x1, y1, x2;
    logic [CHAN_W-1:0] sum_r, sum_g, sum_b;

    assign o_s_tready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tlast   = r_out.frame_last;
    assign o_m_tdata   = {{(OUT_DATA_W - ADDR_W - INDEX_W){1'b0}},
                          r_out.fb_address, r_out.color_index};

    assign take     = i_s_tvalid && o_s_tready;
    assign out_fire = r_out_valid && i_m_tready;

    always_comb begin
        x1 = {1'b0, r_col} + SIZE_W'(1);
        x2 = {1'b0, r_col} + SIZE_W'(2);
        y1 = {1'b0, r_row} + SIZE_W'(1);

        keep   = ({1'b0, r_col} < r_win_w) && ({1'b0, r_row} < r_win_h);
        spread = keep && (r_col != '0) && (x2 <= r_win_w) && (y1 < r_win_h);

        sum_r = sat_add(i_s_tdata[7:0],   {1'b0, r_car_r});
        sum_g = sat_add(i_s_tdata[15:8],  {1'b0, r_car_g});
        sum_b = sat_add(i_s_tdata[23:16], r_car_b);

        res.color_index = {sum_b[7:6], sum_g[7:5], sum_r[7:5]};
        res.fb_address  = r_base + {{(ADDR_W - CNT_W){1'b0}}, r_col};
        res.frame_last  = (x1 == r_win_w) && (y1 == r_win_h);

        n_w = r_w;
        n_h = r_h;
        n_win_w = r_win_w;
        n_win_h = r_win_h;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SOURCE_WIDTH: begin
                    n_w     = eff_size(i_cfg_data);
                    n_win_w = clip(eff_size(i_cfg_data), COLS_LIM);
                end
                CFG_SOURCE_HEIGHT: begin
                    n_h     = eff_size(i_cfg_data);
                    n_win_h = clip(eff_size(i_cfg_data), ROWS_LIM);
                end
                default: begin
                    n_w = r_w;
                end
            endcase
        end

        n_col   = r_col;
        n_row   = r_row;
        n_base  = r_base;
        n_car_r = r_car_r;
        n_car_g = r_car_g;
        n_car_b = r_car_b;
        if (take) begin
            if (spread) begin
                n_car_r = sum_r[4:0];
                n_car_g = sum_g[4:0];
                n_car_b = sum_b[5:0];
            end else begin
                n_car_r = '0;
                n_car_g = '0;
                n_car_b = '0;
            end
            if (x1 >= r_w) begin
                n_col = '0;
                if (y1 >= r_h) begin
                    n_row  = '0;
                    n_base = '0;
                end else begin
                    n_row  = y1[CNT_W-1:0];
                    n_base = r_base + ROW_STEP;
                end
            end else begin
                n_col = x1[CNT_W-1:0];
            end
        end

        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (take && keep) begin
            if (!r_out_valid || out_fire) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (out_fire) begin
            n_out        = r_skid;
            n_out_valid  = r_skid_valid;
            n_skid_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w          <= eff_size(RESET_WIDTH);
            r_h          <= eff_size(RESET_HEIGHT);
            r_win_w      <= clip(eff_size(RESET_WIDTH), COLS_LIM);
            r_win_h      <= clip(eff_size(RESET_HEIGHT), ROWS_LIM);
            r_col        <= '0;
            r_row        <= '0;
            r_base       <= '0;
            r_car_r      <= '0;
            r_car_g      <= '0;
            r_car_b      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_w          <= n_w;
            r_h          <= n_h;
            r_win_w      <= n_win_w;
            r_win_h      <= n_win_h;
            r_col        <= n_col;
            r_row        <= n_row;
            r_base       <= n_base;
            r_car_r      <= n_car_r;
            r_car_g      <= n_car_g;
            r_car_b      <= n_car_b;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    import ed332_pkg::*;

    localparam int WIN_COLS = 320;
    localparam int WIN_ROWS = 208;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_index            i_cfg_index = CFG_SOURCE_WIDTH;
    logic [SIZE_W-1:0]     i_cfg_data  = '0;

    error_diffusion_rgb332_quantizer_top #(
        .MAX_COLS(WIN_COLS),
        .MAX_ROWS(WIN_ROWS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the quantizer state
    logic [SIZE_W-1:0] size_w = RESET_WIDTH;
    logic [SIZE_W-1:0] size_h = RESET_HEIGHT;
    logic [CNT_W-1:0]  px_col = '0;
    logic [CNT_W-1:0]  px_row = '0;
    logic [4:0]        err_r  = '0;
    logic [4:0]        err_g  = '0;
    logic [5:0]        err_b  = '0;

    t_result pending_px[$];
    int      err_count   = 0;
    bit      tx_gaps     = 1'b0;
    bit      rx_throttle = 1'b0;
    int      rx_hold     = 0;

    task automatic report_mismatch(input string msg);
        if (err_count < 40) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        err_count++;
    endtask

    function automatic void quantize_pixel(input logic [IN_DATA_W-1:0] px);
        int      w, h, win_w, win_h, x, y, r, g, b;
        bit      keep, spread;
        t_result res;
        w = (size_w == '0) ? 1 : ((size_w > SIZE_MAX) ? int'(SIZE_MAX) : int'(size_w));
        h = (size_h == '0) ? 1 : ((size_h > SIZE_MAX) ? int'(SIZE_MAX) : int'(size_h));
        win_w = (w < WIN_COLS) ? w : WIN_COLS;
        win_h = (h < WIN_ROWS) ? h : WIN_ROWS;
        x = int'(px_col);
        y = int'(px_row);
        keep   = (x < win_w) && (y < win_h);
        spread = keep && (x >= 1) && (x + 2 <= win_w) && (y + 1 < win_h);
        r = int'(px[7:0])   + int'(err_r);
        g = int'(px[15:8])  + int'(err_g);
        b = int'(px[23:16]) + int'(err_b);
        if (r > 255) r = 255;
        if (g > 255) g = 255;
        if (b > 255) b = 255;
        if (keep) begin
            res.color_index = {b[7:6], g[7:5], r[7:5]};
            res.fb_address  = ADDR_W'(x + y * WIN_COLS);
            res.frame_last  = (x + 1 == win_w) && (y + 1 == win_h);
            pending_px.push_back(res);
        end
        if (spread) begin
            err_r = r[4:0];
            err_g = g[4:0];
            err_b = b[5:0];
        end else begin
            err_r = '0;
            err_g = '0;
            err_b = '0;
        end
        if (x + 1 >= w) begin
            px_col = '0;
            px_row = (y + 1 >= h) ? '0 : CNT_W'(y + 1);
        end else begin
            px_col = CNT_W'(x + 1);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_px.size() == 0) begin
                    report_mismatch($sformatf("unexpected result tdata=%h", o_m_tdata));
                end else begin
                    want = pending_px.pop_front();
                    if (o_m_tdata[7:0] != want.color_index)
                        report_mismatch($sformatf("color_index got %h want %h",
                                                  o_m_tdata[7:0], want.color_index));
                    if (o_m_tdata[24:8] != want.fb_address)
                        report_mismatch($sformatf("fb_address got %0d want %0d",
                                                  o_m_tdata[24:8], want.fb_address));
                    if (o_m_tlast != want.frame_last)
                        report_mismatch($sformatf("tlast got %b want %b at address %0d",
                                                  o_m_tlast, want.frame_last,
                                                  want.fb_address));
                    if (o_m_tdata[31:25] != '0)
                        report_mismatch($sformatf("padding got %h", o_m_tdata[31:25]));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                quantize_pixel(i_s_tdata);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_SOURCE_WIDTH) size_w = i_cfg_data;
                else size_h = i_cfg_data;
            end
        end
    end

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge i_clk) begin
        if (!rx_throttle) begin
            i_m_tready <= 1'b1;
            rx_hold = 0;
        end else if (rx_hold != 0) begin
            rx_hold--;
        end else if ($urandom_range(0, 2) == 0) begin
            i_m_tready <= 1'b0;
            rx_hold = pick_gap();
        end else begin
            i_m_tready <= 1'b1;
            rx_hold = $urandom_range(0, 8);
        end
    end

    function automatic logic [7:0] rand_chan();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 8'd0;
        if (r < 35) return 8'(255 - $urandom_range(0, 31));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [IN_DATA_W-1:0] rand_pixel();
        return {rand_chan(), rand_chan(), rand_chan()};
    endfunction

    task automatic send_pixel(input logic [IN_DATA_W-1:0] px);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        gap = tx_gaps ? pick_gap() : 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // stream idle, every result in, pipeline flushed
    task automatic settle();
        int waited;
        i_s_tvalid <= 1'b0;
        waited = 0;
        while (pending_px.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_px.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_px.size()));
            pending_px.delete();
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_frame(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        for (int k = 0; k < 2; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (k == 0) ? CFG_SOURCE_WIDTH : CFG_SOURCE_HEIGHT;
            i_cfg_data  <= (k == 0) ? w : h;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size(input int limit);
        int r;
        r = $urandom_range(0, 99);
        if (r < 68) return SIZE_W'($urandom_range(1, 10));
        if (r < 74) return '0;
        if (r < 82) return SIZE_W'($urandom_range(limit - 1, limit + 1));
        if (r < 88) return SIZE_MAX;
        if (r < 93) return SIZE_W'($urandom_range(4097, 8191));
        return SIZE_W'($urandom_range(11, 64));
    endfunction

    // reset sizes, saturation and carry corners
    task automatic test_defaults();
        logic [IN_DATA_W-1:0] corner [10] = '{
            24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h3F1F1F, 24'h1F1F3F,
            24'h010101, 24'hC0E0E0, 24'h808080, 24'h7F7F7F, 24'hFEFEFE
        };
        tx_gaps     = 1'b0;
        rx_throttle = 1'b0;
        foreach (corner[i]) send_pixel(corner[i]);
        settle();
    endtask

    // counters left past a smaller size, windows too narrow to carry,
    // zero and oversized register values
    task automatic test_narrow_window();
        set_frame(13'd2, 13'd2);
        repeat (6) send_pixel(rand_pixel());
        settle();
        set_frame(13'd0, 13'd0);
        repeat (3) send_pixel(rand_pixel());
        settle();
        set_frame(13'd3, 13'd2);
        repeat (7) send_pixel(24'hFFFFFF);
        settle();
        set_frame(13'd8191, 13'd4097);
        repeat (4) send_pixel(rand_pixel());
        settle();
        set_frame(SIZE_MAX, SIZE_MAX);
        repeat (3) send_pixel(rand_pixel());
        settle();
    endtask

    // pixels beyond the kept window, under back-pressure
    task automatic test_window_clip();
        tx_gaps     = 1'b1;
        rx_throttle = 1'b1;
        set_frame(13'd1, 13'd212);
        repeat (214) send_pixel(rand_pixel());
        settle();
        set_frame(13'd324, 13'd8191);
        repeat (326) send_pixel(rand_pixel());
        settle();
    endtask

    task automatic test_random_frames();
        int sent;
        int n;
        sent = 0;
        while (sent < 850) begin
            set_frame(pick_size(WIN_COLS), pick_size(WIN_ROWS));
            tx_gaps     = ($urandom_range(0, 3) != 0);
            rx_throttle = ($urandom_range(0, 3) != 0);
            n = $urandom_range(10, 80);
            repeat (n) send_pixel(rand_pixel());
            sent += n;
            settle();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_defaults();
        test_narrow_window();
        test_window_clip();
        test_random_frames();
        settle();
        if (err_count == 0) begin
            $display("[error_diffusion_rgb332_quantizer_top] OK");
        end else begin
            $display("[error_diffusion_rgb332_quantizer_top] ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[error_diffusion_rgb332_quantizer_top] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ed332_pkg.sv
rtl/error_diffusion_rgb332_quantizer_top.sv
dv/testbench.sv
